>>> src/sis_pkg.sv
`default_nettype none
package sis_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int KEY_WIDTH_DEF  = 16;
	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		CMD_SORTED = 2'd0,
		CMD_POP    = 2'd1,
		CMD_PUSH   = 2'd2
	} sis_cmd_t;

	typedef struct packed {
		logic ins;
		logic push;
		logic pop;
	} sis_op_t;

endpackage
`default_nettype wire

>>> src/sis_cell.sv
`default_nettype none
module sis_cell
	import sis_pkg::*;
#(
	parameter int KEY_WIDTH  = KEY_WIDTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire sis_op_t               op,
	input  wire logic                  valid,
	input  wire logic                  found_above,
	input  wire logic [KEY_WIDTH-1:0]  new_key,
	input  wire logic [DATA_WIDTH-1:0] new_data,
	input  wire logic [KEY_WIDTH-1:0]  above_key,
	input  wire logic [DATA_WIDTH-1:0] above_data,
	input  wire logic [KEY_WIDTH-1:0]  below_key,
	input  wire logic [DATA_WIDTH-1:0] below_data,
	output logic                       match,
	output logic [KEY_WIDTH-1:0]       key,
	output logic [DATA_WIDTH-1:0]      data
);

	logic [KEY_WIDTH-1:0]  key_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic                  at_slot;

	assign match   = valid && (key_q >= new_key);
	assign at_slot = !found_above && (op.push || !valid || (key_q >= new_key));
	assign key     = key_q;
	assign data    = data_q;

	always_ff @(posedge clk) begin
		if (op.pop) begin
			key_q  <= below_key;
			data_q <= below_data;
		end else if (op.ins) begin
			if (found_above) begin
				key_q  <= above_key;
				data_q <= above_data;
			end else if (at_slot) begin
				key_q  <= new_key;
				data_q <= new_data;
			end
		end
	end

endmodule
`default_nettype wire

>>> src/sorted_insert_stack.sv
// Sorted insert stack: bounded stack of key/payload entries held in a row of
// cells, cell 0 being the top.
// Input channel (in_valid/in_stall) carries command, start_time and payload.
// A sorted insert places the entry above the first entry, from the top, whose
// key is greater than or equal to its own, or at the bottom if none is; a pop
// removes the top; a plain push puts the entry on top. Every cell compares
// against the new key in parallel and shifts by one place toward its neighbor.
// Output channel (out_valid/out_stall) returns one beat per input beat: top
// key and payload (zero when empty), entry count, empty flag and an overflow
// flag for a sorted insert or push dropped because the stack was full.
// The result beat is registered and is valid the cycle after the input beat is taken.
// Throughput: one beat per cycle while the output beat is not stalled.
// While an output beat is stalled the input is stalled too, so the stack
// holds still until the beat is taken.
// Reset clears the entry count and the output valid; the stack comes up empty.
`default_nettype none
module sorted_insert_stack
	import sis_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int KEY_WIDTH  = KEY_WIDTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   command,
	input  wire logic [KEY_WIDTH-1:0]         start_time,
	input  wire logic [DATA_WIDTH-1:0]        payload,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [KEY_WIDTH-1:0]              top_key,
	output logic [DATA_WIDTH-1:0]             top_payload,
	output logic [$clog2(DEPTH+1)-1:0]        entry_count,
	output logic                              is_empty,
	output logic                              overflow
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]         count_q;
	logic                  out_valid_q;
	logic                  overflow_q;
	logic                  accept;
	logic                  full;
	logic                  is_put;
	sis_op_t               op;
	logic [DEPTH-1:0]      match;
	logic [DEPTH-1:0]      found;
	logic [KEY_WIDTH-1:0]  cell_key  [DEPTH];
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == CW'(DEPTH));
	assign is_put   = (command == CMD_SORTED) || (command == CMD_PUSH);

	always_comb begin
		op.ins  = accept && is_put && !full;
		op.push = (command == CMD_PUSH);
		op.pop  = accept && (command == CMD_POP) && (count_q != '0);
	end

	assign found[0] = 1'b0;

	genvar k;
	generate
		for (k = 1; k < DEPTH; k++) begin : g_found
			assign found[k] = op.push || (|match[k-1:0]);
		end

		for (k = 0; k < DEPTH; k++) begin : g_cell
			logic [KEY_WIDTH-1:0]  above_key;
			logic [DATA_WIDTH-1:0] above_data;
			logic [KEY_WIDTH-1:0]  below_key;
			logic [DATA_WIDTH-1:0] below_data;

			if (k == 0) begin : g_top
				assign above_key  = '0;
				assign above_data = '0;
			end else begin : g_mid_above
				assign above_key  = cell_key[k-1];
				assign above_data = cell_data[k-1];
			end

			if (k == DEPTH - 1) begin : g_bottom
				assign below_key  = '0;
				assign below_data = '0;
			end else begin : g_mid_below
				assign below_key  = cell_key[k+1];
				assign below_data = cell_data[k+1];
			end

			sis_cell #(
				.KEY_WIDTH  (KEY_WIDTH),
				.DATA_WIDTH (DATA_WIDTH)
			) u_cell (
				.clk         (clk),
				.op          (op),
				.valid       (count_q > CW'(k)),
				.found_above (found[k]),
				.new_key     (start_time),
				.new_data    (payload),
				.above_key   (above_key),
				.above_data  (above_data),
				.below_key   (below_key),
				.below_data  (below_data),
				.match       (match[k]),
				.key         (cell_key[k]),
				.data        (cell_data[k])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			overflow_q  <= 1'b0;
		end else begin
			if (op.ins) begin
				count_q <= count_q + CW'(1);
			end else if (op.pop) begin
				count_q <= count_q - CW'(1);
			end
			if (accept) begin
				out_valid_q <= 1'b1;
				overflow_q  <= is_put && full;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign entry_count = count_q;
	assign is_empty    = (count_q == '0);
	assign overflow    = overflow_q;
	assign top_key     = (count_q != '0) ? cell_key[0] : '0;
	assign top_payload = (count_q != '0) ? cell_data[0] : '0;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> entry_count == CW'(DEPTH))
		else $error("overflow reported while not full");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_put && !full |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the stack");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (command == CMD_POP) && (count_q == '0) |=> count_q == '0)
		else $error("pop on empty changed the count");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(count_q) && $stable(top_key))
		else $error("stack changed while output beat stalled");
`endif

endmodule
`default_nettype wire

>>> bench/sis_checker.sv
`default_nettype none
module sis_checker
	import sis_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int KEY_WIDTH  = KEY_WIDTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic                         in_stall,
	input  wire logic [1:0]                   command,
	input  wire logic [KEY_WIDTH-1:0]         start_time,
	input  wire logic [DATA_WIDTH-1:0]        payload,
	input  wire logic                         out_valid,
	input  wire logic                         out_stall,
	input  wire logic [KEY_WIDTH-1:0]         top_key,
	input  wire logic [DATA_WIDTH-1:0]        top_payload,
	input  wire logic [$clog2(DEPTH+1)-1:0]   entry_count,
	input  wire logic                         is_empty,
	input  wire logic                         overflow,
	output int                                fail_count,
	output int                                pending
);

	localparam int CW = $clog2(DEPTH+1);

	typedef struct packed {
		logic [KEY_WIDTH-1:0]  key;
		logic [DATA_WIDTH-1:0] data;
		logic [CW-1:0]         count;
		logic                  empty;
		logic                  ovf;
	} stack_view_t;

	logic [KEY_WIDTH-1:0]  key_store [DEPTH];
	logic [DATA_WIDTH-1:0] data_store [DEPTH];
	int                    level;
	stack_view_t           view_q [$];

	function automatic stack_view_t apply_command(input logic [1:0] cmd,
		input logic [KEY_WIDTH-1:0] key, input logic [DATA_WIDTH-1:0] data);
		stack_view_t v;
		int slot;
		v = '0;
		if (cmd == CMD_SORTED || cmd == CMD_PUSH) begin
			if (level >= DEPTH) begin
				v.ovf = 1'b1;
			end else begin
				slot = level;
				if (cmd == CMD_SORTED) begin
					slot = 0;
					for (int i = level; i > 0 && slot == 0; i--)
						if (key_store[i-1] >= key)
							slot = i;
				end
				for (int j = level; j > slot; j--) begin
					key_store[j]  = key_store[j-1];
					data_store[j] = data_store[j-1];
				end
				key_store[slot]  = key;
				data_store[slot] = data;
				level++;
			end
		end else if (cmd == CMD_POP) begin
			if (level > 0)
				level--;
		end
		if (level > 0) begin
			v.key  = key_store[level-1];
			v.data = data_store[level-1];
		end
		v.count = level[CW-1:0];
		v.empty = (level == 0);
		return v;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stack_view_t want;
		if (!arst_n) begin
			level = 0;
			view_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				view_q.push_back(apply_command(command, start_time, payload));
			if (out_valid && !out_stall) begin
				if (view_q.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with nothing expected, actual key %0h count %0d",
						$time, top_key, entry_count);
				end else begin
					want = view_q.pop_front();
					check_field("top_key", 64'(want.key), 64'(top_key));
					check_field("top_payload", 64'(want.data), 64'(top_payload));
					check_field("entry_count", 64'(want.count), 64'(entry_count));
					check_field("is_empty", 64'(want.empty), 64'(is_empty));
					check_field("overflow", 64'(want.ovf), 64'(overflow));
				end
			end
			pending <= view_q.size();
		end
	end

endmodule
`default_nettype wire

>>> bench/tb_sorted_insert_stack.sv
`default_nettype none
module tb_sorted_insert_stack;
	import sis_pkg::*;

	localparam int DEPTH          = DEPTH_DEF;
	localparam int KW             = KEY_WIDTH_DEF;
	localparam int DW             = DATA_WIDTH_DEF;
	localparam int CW             = $clog2(DEPTH+1);
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int EPISODES       = 13;
	localparam int EPISODE_LEN    = 40;
	localparam int MODE_FILL      = 0;
	localparam int MODE_DRAIN     = 1;
	localparam int MODE_MIXED     = 2;

	logic            clk        = 1'b0;
	logic            arst_n     = 1'b0;
	logic            in_valid   = 1'b0;
	logic            in_stall;
	logic [1:0]      command    = '0;
	logic [KW-1:0]   start_time = '0;
	logic [DW-1:0]   payload    = '0;
	logic            out_valid;
	logic            out_stall  = 1'b0;
	logic [KW-1:0]   top_key;
	logic [DW-1:0]   top_payload;
	logic [CW-1:0]   entry_count;
	logic            is_empty;
	logic            overflow;

	int fail_count;
	int pending;
	int idle_pct      = 34;
	int stall_pct     = 34;
	int hold_requests = 0;
	int holds_done    = 0;
	int beats_sent    = 0;
	int quiet         = 0;

	sorted_insert_stack #(
		.DEPTH(DEPTH), .KEY_WIDTH(KW), .DATA_WIDTH(DW)
	) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .start_time(start_time), .payload(payload),
		.out_valid(out_valid), .out_stall(out_stall),
		.top_key(top_key), .top_payload(top_payload), .entry_count(entry_count),
		.is_empty(is_empty), .overflow(overflow)
	);

	sis_checker #(
		.DEPTH(DEPTH), .KEY_WIDTH(KW), .DATA_WIDTH(DW)
	) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .start_time(start_time), .payload(payload),
		.out_valid(out_valid), .out_stall(out_stall),
		.top_key(top_key), .top_payload(top_payload), .entry_count(entry_count),
		.is_empty(is_empty), .overflow(overflow),
		.fail_count(fail_count), .pending(pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("FAILURE");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_beat(input logic [1:0] cmd, input logic [KW-1:0] key,
		input logic [DW-1:0] data);
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		start_time <= key;
		payload    <= data;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	function automatic logic [KW-1:0] pick_key(input bit narrow);
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 16)
			return '1;
		if (narrow)
			return KW'($urandom_range(0, 7));
		return KW'($urandom);
	endfunction

	function automatic logic [1:0] pick_command(input int mode);
		int r;
		int pop_pct;
		r = $urandom_range(99);
		pop_pct = (mode == MODE_FILL) ? 20 : (mode == MODE_DRAIN) ? 70 : 45;
		if (r < 3)
			return CMD_UNUSED;
		if (r < 3 + pop_pct)
			return CMD_POP;
		return ($urandom_range(3) == 0) ? CMD_PUSH : CMD_SORTED;
	endfunction

	initial begin
		int mode;
		bit narrow;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(CMD_POP, 16'h1111, 32'h1111_1111);
		send_beat(CMD_UNUSED, 16'h2222, 32'h2222_2222);
		send_beat(CMD_SORTED, '0, '0);
		send_beat(CMD_SORTED, '1, '1);
		send_beat(CMD_SORTED, '0, 32'hA5A5_A5A5);
		send_beat(CMD_SORTED, 16'h8000, 32'h5A5A_5A5A);
		send_beat(CMD_PUSH, 16'h0001, 32'h0000_0001);
		send_beat(CMD_SORTED, '0, 32'h0000_0002);
		send_beat(CMD_POP, '1, '1);
		send_beat(CMD_UNUSED, '1, '1);
		send_beat(CMD_PUSH, '1, '1);
		send_beat(CMD_SORTED, '1, 32'h8000_0000);
		// fill to the brim, then push into a full stack both ways
		repeat (DEPTH - 7)
			send_beat(CMD_PUSH, KW'($urandom), DW'($urandom));
		send_beat(CMD_SORTED, '0, 32'hDEAD_BEEF);
		send_beat(CMD_PUSH, '1, 32'hFFFF_0000);
		wait_drained();

		for (int e = 0; e < EPISODES; e++) begin
			mode = e % 3;
			narrow = 1'($urandom_range(1));
			idle_pct = 34;
			stall_pct = 34;
			if (e == 4) begin
				idle_pct = 0;
				stall_pct = 0;
			end
			if (e == 6) begin
				idle_pct = 0;
				mode = MODE_FILL;
				hold_requests++;
			end
			if (e == 9)
				wait_drained();
			for (int k = 0; k < EPISODE_LEN; k++)
				send_beat(pick_command(mode), pick_key(narrow), DW'($urandom));
		end
		wait_drained();

		$display("Sent %0d beats of sorted inserts, pops, plain pushes and unused codes,",
			beats_sent);
		$display("filling past full and popping past empty under random and long stalls.");
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
